### rtl/qapm_pkg.sv
// shared types, register codes and constants of the attitude pid mixer
package qapm_pkg;

  localparam int INTEGRAL_LIMIT_DEF = 12800;
  localparam int OUTPUT_LIMIT_DEF   = 200;
  localparam int THROTTLE_BITS_DEF  = 11;

  localparam int GAIN_W   = 16;
  localparam int ANGLE_W  = 16;
  localparam int RATE_W   = 16;
  localparam int ERR_W    = 17;
  localparam int INTEG_W  = 15;
  localparam int HELD_W   = 9;
  localparam int OPND_W   = 18;
  localparam int PROD_W   = 35;
  localparam int ACC_W    = 37;
  localparam int FRAC_W   = 19;
  localparam int MOTOR_W  = 13;
  localparam int CFG_IDX_W = 4;

  localparam int ONE_DEGREE      = 128;
  localparam int TILT_LIMIT      = 6400;
  localparam int IDLE_THROTTLE   = 850;
  localparam int CUTOFF_THROTTLE = 800;
  localparam int RATE_SCALE      = 125;
  localparam int RATE_SHIFT      = 5;
  localparam int TRIM_TWO        = 15;
  localparam int TRIM_THREE      = 20;
  localparam int IDLE_TRIM_ONE   = 3;
  localparam int IDLE_TRIM_FOUR  = 5;

  localparam logic [CFG_IDX_W-1:0] REG_P_ROLL  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_I_ROLL  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_ROLL  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_P_PITCH = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_I_PITCH = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_D_PITCH = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_P_YAW   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_D_YAW   = 4'd7;

  localparam logic [GAIN_W-1:0] RST_P_ROLL  = 16'd8192;
  localparam logic [GAIN_W-1:0] RST_I_ROLL  = 16'd0;
  localparam logic [GAIN_W-1:0] RST_D_ROLL  = 16'd7168;
  localparam logic [GAIN_W-1:0] RST_P_PITCH = 16'd7373;
  localparam logic [GAIN_W-1:0] RST_I_PITCH = 16'd20;
  localparam logic [GAIN_W-1:0] RST_D_PITCH = 16'd5939;
  localparam logic [GAIN_W-1:0] RST_P_YAW   = 16'd4096;
  localparam logic [GAIN_W-1:0] RST_D_YAW   = 16'd0;

  typedef enum logic [1:0] {
    AXIS_ROLL  = 2'd0,
    AXIS_PITCH = 2'd1,
    AXIS_YAW   = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } term_t;

  typedef struct packed {
    logic  load;
    logic  axis_start;
    logic  mul_en;
    logic  acc_en;
    logic  scale_en;
    logic  mix_en;
    axis_t axis;
    term_t term;
  } ctrl_cmd_t;

  typedef struct packed {
    logic small_err;
    logic out_free;
  } ctrl_stat_t;

endpackage

### rtl/qapm_ctrl.sv
// sequencer that walks the three axes through the shared multiplier
module qapm_ctrl import qapm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_AXIS  = 6'b000010,
    S_MUL   = 6'b000100,
    S_ACC   = 6'b001000,
    S_SCALE = 6'b010000,
    S_MIX   = 6'b100000
  } state_t;

  state_t state, state_next;
  axis_t  axis, axis_next;
  term_t  term, term_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= AXIS_ROLL;
      term  <= TERM_P;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      term  <= term_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    axis_next      = axis;
    term_next      = term;
    cmd            = '0;
    cmd.axis       = axis;
    cmd.term       = term;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          axis_next  = AXIS_ROLL;
          state_next = S_AXIS;
        end
      end
      S_AXIS: begin
        cmd.axis_start = 1'b1;
        term_next      = TERM_P;
        if (!stat.small_err) begin
          state_next = S_MUL;
        end else if (axis == AXIS_YAW) begin
          state_next = S_MIX;
        end else begin
          axis_next = axis_t'(axis + 2'd1);
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.acc_en = (term != TERM_P);
        if (term == TERM_D) begin
          state_next = S_ACC;
        end else begin
          term_next = term_t'(term + 2'd1);
        end
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale_en = 1'b1;
        if (axis == AXIS_YAW) begin
          state_next = S_MIX;
        end else begin
          axis_next  = axis_t'(axis + 2'd1);
          state_next = S_AXIS;
        end
      end
      S_MIX: begin
        if (stat.out_free) begin
          cmd.mix_en = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/qapm_dp.sv
// gain registers, per-axis pid arithmetic, motor mixing and output register
module qapm_dp import qapm_pkg::*; #(
  parameter int INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF,
  parameter int OUTPUT_LIMIT   = OUTPUT_LIMIT_DEF,
  parameter int THROTTLE_BITS  = THROTTLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ctrl_cmd_t                   cmd,
  output ctrl_stat_t                  stat,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [GAIN_W-1:0]           cfg_data,
  input  logic signed [ANGLE_W-1:0]   roll_angle,
  input  logic signed [ANGLE_W-1:0]   pitch_angle,
  input  logic signed [ANGLE_W-1:0]   yaw_angle,
  input  logic signed [ANGLE_W-1:0]   roll_target,
  input  logic signed [ANGLE_W-1:0]   pitch_target,
  input  logic signed [ANGLE_W-1:0]   yaw_target,
  input  logic signed [RATE_W-1:0]    rate_x,
  input  logic signed [RATE_W-1:0]    rate_y,
  input  logic signed [RATE_W-1:0]    rate_z,
  input  logic [THROTTLE_BITS-1:0]    throttle_cmd,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [MOTOR_W-1:0]   motor_one,
  output logic signed [MOTOR_W-1:0]   motor_two,
  output logic signed [MOTOR_W-1:0]   motor_three,
  output logic signed [MOTOR_W-1:0]   motor_four
);

  localparam int TW = (THROTTLE_BITS > 10) ? THROTTLE_BITS : 10;
  localparam int MW = TW + 3;
  localparam int RP_W = RATE_W + 7;
  localparam int Q_W = ACC_W - FRAC_W;

  localparam logic signed [OPND_W-1:0] INTEG_LIM = OPND_W'(INTEGRAL_LIMIT);
  localparam logic signed [Q_W-1:0]    OUT_LIM   = Q_W'(OUTPUT_LIMIT);
  localparam logic signed [ACC_W-1:0]  TRUNC_BIAS = ACC_W'((1 << FRAC_W) - 1);
  localparam logic signed [ERR_W-1:0]  ERR_SMALL = ERR_W'(ONE_DEGREE);
  localparam logic signed [ANGLE_W-1:0] TILT_LIM = ANGLE_W'(TILT_LIMIT);

  logic [GAIN_W-1:0] gp_roll, gi_roll, gd_roll, gp_pitch, gi_pitch, gd_pitch;
  logic [GAIN_W-1:0] gp_yaw, gd_yaw;

  always_ff @(posedge clk) begin
    if (rst) begin
      gp_roll  <= RST_P_ROLL;
      gi_roll  <= RST_I_ROLL;
      gd_roll  <= RST_D_ROLL;
      gp_pitch <= RST_P_PITCH;
      gi_pitch <= RST_I_PITCH;
      gd_pitch <= RST_D_PITCH;
      gp_yaw   <= RST_P_YAW;
      gd_yaw   <= RST_D_YAW;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_P_ROLL:  gp_roll  <= cfg_data;
        REG_I_ROLL:  gi_roll  <= cfg_data;
        REG_D_ROLL:  gd_roll  <= cfg_data;
        REG_P_PITCH: gp_pitch <= cfg_data;
        REG_I_PITCH: gi_pitch <= cfg_data;
        REG_D_PITCH: gd_pitch <= cfg_data;
        REG_P_YAW:   gp_yaw   <= cfg_data;
        REG_D_YAW:   gd_yaw   <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured item
  logic signed [ANGLE_W-1:0] meas [3];
  logic signed [ANGLE_W-1:0] targ [3];
  logic signed [RATE_W-1:0]  gyro [3];
  logic [THROTTLE_BITS-1:0]  thr;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      meas[0] <= roll_angle;
      meas[1] <= pitch_angle;
      meas[2] <= yaw_angle;
      targ[0] <= roll_target;
      targ[1] <= pitch_target;
      targ[2] <= yaw_target;
      gyro[0] <= rate_x;
      gyro[1] <= rate_y;
      gyro[2] <= rate_z;
      thr     <= throttle_cmd;
    end
  end

  // axis setup: error, integral, rate term
  logic signed [ANGLE_W-1:0] sel_meas, sel_targ;
  logic signed [RATE_W-1:0]  sel_gyro;
  logic signed [ERR_W-1:0]   err;
  logic                      small_err;
  logic signed [INTEG_W-1:0] integ [3];
  logic signed [INTEG_W-1:0] sel_integ;
  logic signed [OPND_W-1:0]  integ_sum, integ_clamped;
  logic signed [RP_W-1:0]    rate_prod;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [OPND_W-1:0]  rate_r;
  logic signed [HELD_W-1:0]  held [3];
  logic signed [HELD_W-1:0]  held_next;

  always_comb begin
    case (cmd.axis)
      AXIS_ROLL: begin
        sel_meas = meas[0]; sel_targ = targ[0]; sel_gyro = gyro[0]; sel_integ = integ[0];
      end
      AXIS_PITCH: begin
        sel_meas = meas[1]; sel_targ = targ[1]; sel_gyro = gyro[1]; sel_integ = integ[1];
      end
      default: begin
        sel_meas = meas[2]; sel_targ = targ[2]; sel_gyro = gyro[2]; sel_integ = integ[2];
      end
    endcase
  end

  assign err       = {sel_meas[ANGLE_W-1], sel_meas} - {sel_targ[ANGLE_W-1], sel_targ};
  assign small_err = (err <= ERR_SMALL) && (err >= -ERR_SMALL);
  assign integ_sum = {{(OPND_W-INTEG_W){sel_integ[INTEG_W-1]}}, sel_integ}
                   + {{(OPND_W-ERR_W){err[ERR_W-1]}}, err};
  assign integ_clamped = (integ_sum > INTEG_LIM)  ? INTEG_LIM :
                         (integ_sum < -INTEG_LIM) ? -INTEG_LIM : integ_sum;
  assign rate_prod = {{(RP_W-RATE_W){sel_gyro[RATE_W-1]}}, sel_gyro} * RP_W'(RATE_SCALE);

  always_ff @(posedge clk) begin
    if (cmd.axis_start) begin
      err_r  <= err;
      rate_r <= rate_prod[RP_W-1:RATE_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        integ[i] <= '0;
        held[i]  <= '0;
      end
    end else begin
      if (cmd.axis_start && !small_err) begin
        integ[cmd.axis] <= integ_clamped[INTEG_W-1:0];
      end
      if (cmd.scale_en) begin
        held[cmd.axis] <= held_next;
      end
    end
  end

  // shared multiplier and accumulator
  logic [GAIN_W-1:0]         gain;
  logic signed [OPND_W-1:0]  opnd;
  logic signed [GAIN_W:0]    gain_s;
  logic signed [PROD_W-1:0]  prod, prod_next;
  logic signed [ACC_W-1:0]   acc;

  always_comb begin
    gain = '0;
    case (cmd.axis)
      AXIS_ROLL: begin
        case (cmd.term)
          TERM_P:  gain = gp_roll;
          TERM_I:  gain = gi_roll;
          default: gain = gd_roll;
        endcase
      end
      AXIS_PITCH: begin
        case (cmd.term)
          TERM_P:  gain = gp_pitch;
          TERM_I:  gain = gi_pitch;
          default: gain = gd_pitch;
        endcase
      end
      default: begin
        case (cmd.term)
          TERM_P:  gain = gp_yaw;
          TERM_I:  gain = '0;
          default: gain = gd_yaw;
        endcase
      end
    endcase
  end

  always_comb begin
    case (cmd.term)
      TERM_P:  opnd = {{(OPND_W-ERR_W){err_r[ERR_W-1]}}, err_r};
      TERM_I:  opnd = {{(OPND_W-INTEG_W){sel_integ[INTEG_W-1]}}, sel_integ};
      default: opnd = rate_r;
    endcase
  end

  assign gain_s    = {1'b0, gain};
  assign prod_next = gain_s * opnd;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= prod_next;
    end
    if (cmd.axis_start) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // truncate toward zero, then clamp
  logic signed [ACC_W-1:0]  acc_biased;
  logic signed [Q_W-1:0]    quot;

  assign acc_biased = acc + (acc[ACC_W-1] ? TRUNC_BIAS : '0);
  assign quot       = acc_biased[ACC_W-1:FRAC_W];
  always_comb begin
    if (quot > OUT_LIM) begin
      held_next = OUT_LIM[HELD_W-1:0];
    end else if (quot < -OUT_LIM) begin
      held_next = HELD_W'(-OUT_LIM);
    end else begin
      held_next = quot[HELD_W-1:0];
    end
  end

  // motor mixing
  logic                  tilt;
  logic signed [MW-1:0]  t_eff, r_ext, p_ext, y_ext;
  logic signed [MW-1:0]  m1, m2, m3, m4;

  assign tilt = (meas[0] > TILT_LIM) || (meas[0] < -TILT_LIM)
             || (meas[1] > TILT_LIM) || (meas[1] < -TILT_LIM);
  assign t_eff = tilt ? MW'(CUTOFF_THROTTLE) : MW'(thr);
  assign r_ext = {{(MW-HELD_W){held[0][HELD_W-1]}}, held[0]};
  assign p_ext = {{(MW-HELD_W){held[1][HELD_W-1]}}, held[1]};
  assign y_ext = {{(MW-HELD_W){held[2][HELD_W-1]}}, held[2]};

  always_comb begin
    if (t_eff > MW'(IDLE_THROTTLE)) begin
      m1 = t_eff - p_ext + y_ext;
      m2 = t_eff - r_ext + MW'(TRIM_TWO) - y_ext;
      m3 = t_eff + p_ext + MW'(TRIM_THREE) + y_ext;
      m4 = t_eff + r_ext - y_ext;
    end else begin
      m1 = t_eff - MW'(IDLE_TRIM_ONE);
      m2 = t_eff;
      m3 = t_eff;
      m4 = t_eff - MW'(IDLE_TRIM_FOUR);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.mix_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mix_en) begin
      motor_one   <= m1[MOTOR_W-1:0];
      motor_two   <= m2[MOTOR_W-1:0];
      motor_three <= m3[MOTOR_W-1:0];
      motor_four  <= m4[MOTOR_W-1:0];
    end
  end

  assign stat.small_err = small_err;
  assign stat.out_free  = !out_valid || !out_stall;

endmodule

### rtl/quad_attitude_pid_mixer_top.sv
// top level of the quadcopter attitude pid controller with motor mixing
//
//  channel   signals                         item
//  in        in_valid / in_stall             angles, targets, gyro rates, throttle
//  out       out_valid / out_stall           four motor drive values
//  cfg       cfg_valid / cfg_ready           gain register index and data
//
// with all three axes updating, an item runs from one acceptance to the next through
// the accept step; per axis a setup step, the P, I and D products on the shared 17x18
// multiplier, an accumulate and a scale step; the mix step then registers the result
// an axis with an error of one degree or less keeps its integral and held output
// rst clears the integrals, held outputs and output valid and loads default gains
// the next item is taken once the mix has loaded the output register; a stalled
// result holds the block in the mix step until the register frees
module quad_attitude_pid_mixer_top import qapm_pkg::*; #(
  parameter int INTEGRAL_LIMIT = INTEGRAL_LIMIT_DEF,
  parameter int OUTPUT_LIMIT   = OUTPUT_LIMIT_DEF,
  parameter int THROTTLE_BITS  = THROTTLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [ANGLE_W-1:0]   roll_angle,
  input  logic signed [ANGLE_W-1:0]   pitch_angle,
  input  logic signed [ANGLE_W-1:0]   yaw_angle,
  input  logic signed [ANGLE_W-1:0]   roll_target,
  input  logic signed [ANGLE_W-1:0]   pitch_target,
  input  logic signed [ANGLE_W-1:0]   yaw_target,
  input  logic signed [RATE_W-1:0]    rate_x,
  input  logic signed [RATE_W-1:0]    rate_y,
  input  logic signed [RATE_W-1:0]    rate_z,
  input  logic [THROTTLE_BITS-1:0]    throttle_cmd,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [MOTOR_W-1:0]   motor_one,
  output logic signed [MOTOR_W-1:0]   motor_two,
  output logic signed [MOTOR_W-1:0]   motor_three,
  output logic signed [MOTOR_W-1:0]   motor_four,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [GAIN_W-1:0]           cfg_data
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  assign cfg_ready = 1'b1;

  qapm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  qapm_dp #(
    .INTEGRAL_LIMIT (INTEGRAL_LIMIT),
    .OUTPUT_LIMIT   (OUTPUT_LIMIT),
    .THROTTLE_BITS  (THROTTLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .roll_angle   (roll_angle),
    .pitch_angle  (pitch_angle),
    .yaw_angle    (yaw_angle),
    .roll_target  (roll_target),
    .pitch_target (pitch_target),
    .yaw_target   (yaw_target),
    .rate_x       (rate_x),
    .rate_y       (rate_y),
    .rate_z       (rate_z),
    .throttle_cmd (throttle_cmd),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .motor_one    (motor_one),
    .motor_two    (motor_two),
    .motor_three  (motor_three),
    .motor_four   (motor_four)
  );

endmodule

### rtl/qapm_checker.sv
// port-level checks of the attitude pid mixer, bound to the top level
module qapm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken while previous item still in work");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !(out_valid && !$past(out_valid)))
    else $error("result appeared one cycle after its item");

  a_ready_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("block not ready after loading a result");

endmodule

bind quad_attitude_pid_mixer_top qapm_checker u_qapm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
